// ----- hdl/dlmr_pkg.sv -----
// Shared types and constants for the dual LCG decimal mix generator.
package dlmr_pkg;

    typedef enum logic [1:0] {
        OP_RESEED = 2'd0,
        OP_NEXT   = 2'd1,
        OP_RANGE  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LCG_A,
        ST_LCG_B,
        ST_SPLIT,
        ST_MIX,
        ST_RNG_PREP,
        ST_DIV,
        ST_RNG_ADD,
        ST_OUT
    } t_state;

    localparam int WARMUP_STEPS = 10;
    localparam int WARM_W       = 4;
    localparam int DIGITS       = 10;
    localparam int DIG_W        = 4;

    localparam logic [31:0] MUL_A = 32'd1103515245;
    localparam logic [31:0] INC_A = 32'd12345;
    localparam logic [31:0] MUL_B = 32'd1664525;
    localparam logic [31:0] INC_B = 32'd1013904223;

    localparam logic [1:0] REG_SEED_FIRST  = 2'd0;
    localparam logic [1:0] REG_SEED_SECOND = 2'd1;

endpackage

// ----- hdl/dlmr_if.sv -----
// Valid/ready channel interfaces.
interface dlmr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [63:0] range_low;
    logic [63:0] range_high;
    modport source (output valid, op, range_low, range_high, input ready);
    modport sink   (input valid, op, range_low, range_high, output ready);
endinterface

interface dlmr_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    modport source (output valid, value, input ready);
    modport sink   (input valid, value, output ready);
endinterface

// ----- hdl/dlmr_div.sv -----
// Restoring 64-bit remainder unit, one quotient bit per cycle.
module dlmr_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_rem
);
    logic [63:0] r_num;
    logic [64:0] r_rem;
    logic [63:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] w_sh;
    logic [64:0] w_sub;

    assign w_sh  = {r_rem[63:0], r_num[63]};
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[62:0], 1'b0};
                r_rem <= w_sub[64] ? w_sh : w_sub;
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[63:0];
endmodule

// ----- hdl/dual_lcg_decimal_mix_rng.sv -----
// Top level of the dual LCG decimal mix random number generator.
//
// Input channel (dlmr_in_if): op, range_low, range_high; one beat per
// request. Output channel (dlmr_out_if): one value beat for each next or
// range request; reseed and op 3 give no beat. Seeds are written over the
// APB port (seed_first at 0x0, seed_second at 0x4) while the block is
// idle; the user must keep to this, the block itself does not enforce it.
//
// One request is worked at a time; ready is low from acceptance until the
// block is back in idle, in the cycle after the result beat leaves. A step
// is a pass of each generator through the shared 32x32 multiplier, a split
// of ten digits (one digit of both states per cycle, quotient by ten via a
// reciprocal multiply) and a shift-add rebuild of one to ten result digits,
// one per cycle. For next, the result beat is raised as the last digit is
// rebuilt. Range adds a prep state, the bit-serial remainder unit and an add
// state; a full span skips the remainder unit. Reseed runs ten silent steps.
//
// Reset clears seeds, both generator states and the step count; no warm-up
// is run at reset. If the receiver stalls, the result beat holds in the
// output register and no new request is taken until it is taken.
module dual_lcg_decimal_mix_rng (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dlmr_in_if.sink       in_ch,
    dlmr_out_if.source    out_ch,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    dlmr_pkg::t_state r_state, n_state;

    logic [30:0] r_seed_a;
    logic [31:0] r_seed_b;
    logic [30:0] r_lcg_a;
    logic [31:0] r_lcg_b;
    logic [3:0]  r_cnt;
    logic [1:0]  r_op;
    logic [63:0] r_lo, r_hi;
    logic [dlmr_pkg::WARM_W-1:0] r_warm;
    logic [31:0] r_va, r_vb;
    logic [39:0] r_digs;          // ten mixed digits, position 0 in low nibble
    logic [3:0]  r_len;           // longest digit count, at least one after split
    logic [3:0]  r_idx;
    logic [63:0] r_acc;
    logic [63:0] r_val;
    logic        r_ovalid;
    logic [63:0] r_span;

    // shared multiplier: 32 x 32
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    assign w_prod = {32'd0, w_ma} * {32'd0, w_mb};

    // quotient by ten: multiply by ceil(2^35/10), keep bits 63:35
    logic [63:0] w_pa, w_pb;
    logic [3:0]  w_da, w_db, w_mix;
    logic [4:0]  w_sum;
    logic [31:0] w_qa, w_qb;
    assign w_pa = {32'd0, r_va} * 64'h0000_0000_CCCC_CCCD;
    assign w_pb = {32'd0, r_vb} * 64'h0000_0000_CCCC_CCCD;
    assign w_qa = w_pa[63:32] >> 3;
    assign w_qb = w_pb[63:32] >> 3;
    assign w_da = 4'(r_va - w_qa * 32'd10);
    assign w_db = 4'(r_vb - w_qb * 32'd10);
    always_comb begin
        w_sum = 5'(w_da) + 5'(w_db) + 5'(r_cnt);
        if (w_sum >= 5'd20)      w_mix = 4'(w_sum - 5'd20);
        else if (w_sum >= 5'd10) w_mix = 4'(w_sum - 5'd10);
        else                     w_mix = 4'(w_sum);
    end

    logic [3:0]  w_dig;
    assign w_dig = r_digs[r_idx*4 +: 4];

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            dlmr_pkg::ST_LCG_A: begin
                w_ma = {1'b0, r_lcg_a};
                w_mb = dlmr_pkg::MUL_A;
            end
            dlmr_pkg::ST_LCG_B: begin
                w_ma = r_lcg_b;
                w_mb = dlmr_pkg::MUL_B;
            end
            default: begin
            end
        endcase
    end

    // acc*10 without the multiplier: 64-bit shift add
    logic [63:0] w_acc10;
    assign w_acc10 = (r_acc << 3) + (r_acc << 1) + 64'(w_dig);

    logic        w_div_start, w_div_done;
    logic [63:0] w_rem;
    dlmr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_val),
        .i_den   (r_span),
        .o_done  (w_div_done),
        .o_rem   (w_rem)
    );

    logic w_in_acc, w_out_acc, w_wr;
    assign w_in_acc  = in_ch.valid && in_ch.ready;
    assign w_out_acc = out_ch.valid && out_ch.ready;
    assign w_wr      = psel && penable && pwrite;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dlmr_pkg::ST_IDLE:
                if (w_in_acc && in_ch.op != dlmr_pkg::OP_NONE) n_state = dlmr_pkg::ST_LCG_A;
            dlmr_pkg::ST_LCG_A: n_state = dlmr_pkg::ST_LCG_B;
            dlmr_pkg::ST_LCG_B: n_state = dlmr_pkg::ST_SPLIT;
            dlmr_pkg::ST_SPLIT:
                if (r_idx == 4'(dlmr_pkg::DIGITS - 1)) n_state = dlmr_pkg::ST_MIX;
            dlmr_pkg::ST_MIX:
                if (r_idx == r_len - 4'd1) begin
                    if (r_op == dlmr_pkg::OP_RESEED)
                        n_state = (r_warm == 4'd1) ? dlmr_pkg::ST_IDLE
                                                   : dlmr_pkg::ST_LCG_A;
                    else if (r_op == dlmr_pkg::OP_RANGE)
                        n_state = dlmr_pkg::ST_RNG_PREP;
                    else
                        n_state = dlmr_pkg::ST_OUT;
                end
            dlmr_pkg::ST_RNG_PREP:
                n_state = (r_span == 64'd0) ? dlmr_pkg::ST_OUT : dlmr_pkg::ST_DIV;
            dlmr_pkg::ST_DIV:     if (w_div_done) n_state = dlmr_pkg::ST_RNG_ADD;
            dlmr_pkg::ST_RNG_ADD: n_state = dlmr_pkg::ST_OUT;
            dlmr_pkg::ST_OUT:     if (w_out_acc) n_state = dlmr_pkg::ST_IDLE;
            default:              n_state = dlmr_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ch.ready = (r_state == dlmr_pkg::ST_IDLE);
        w_div_start = (r_state == dlmr_pkg::ST_RNG_PREP) && (r_span != 64'd0);
    end
    assign out_ch.valid = r_ovalid;
    assign out_ch.value = r_val;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b1) ? r_seed_b : {1'b0, r_seed_a};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dlmr_pkg::ST_IDLE;
            r_seed_a <= '0;
            r_seed_b <= '0;
            r_lcg_a  <= '0;
            r_lcg_b  <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_warm   <= '0;
            r_idx    <= '0;
        end else begin
            r_state <= n_state;
            if (w_wr) begin
                unique case (2'(paddr[2]))
                    dlmr_pkg::REG_SEED_FIRST:  r_seed_a <= pwdata[30:0];
                    dlmr_pkg::REG_SEED_SECOND: r_seed_b <= pwdata;
                    default: begin
                    end
                endcase
            end
            case (r_state)
                dlmr_pkg::ST_IDLE: if (w_in_acc) begin
                    r_op <= in_ch.op;
                    if (in_ch.range_low > in_ch.range_high) begin
                        r_lo <= in_ch.range_high;
                        r_hi <= in_ch.range_low;
                    end else begin
                        r_lo <= in_ch.range_low;
                        r_hi <= in_ch.range_high;
                    end
                    if (in_ch.op == dlmr_pkg::OP_RESEED) begin
                        r_lcg_a <= r_seed_a;
                        r_lcg_b <= r_seed_b;
                        r_cnt   <= '0;
                        r_warm  <= 4'(dlmr_pkg::WARMUP_STEPS);
                    end
                end
                dlmr_pkg::ST_LCG_A: begin
                    r_lcg_a <= 31'(w_prod[30:0] + dlmr_pkg::INC_A[30:0]);
                    r_cnt   <= (r_cnt == 4'd9) ? 4'd0 : r_cnt + 4'd1;
                    r_len   <= '0;
                    r_idx   <= '0;
                end
                dlmr_pkg::ST_LCG_B: begin
                    r_lcg_b <= w_prod[31:0] + dlmr_pkg::INC_B;
                    r_va    <= {1'b0, r_lcg_a};
                    r_vb    <= w_prod[31:0] + dlmr_pkg::INC_B;
                end
                dlmr_pkg::ST_SPLIT: begin
                    r_digs[r_idx*4 +: 4] <= w_mix;
                    r_va <= w_qa;
                    r_vb <= w_qb;
                    if (r_idx == 4'(dlmr_pkg::DIGITS - 1)) begin
                        // final length, padded to one digit; rebuild from position 0
                        if (r_va != 32'd0 || r_vb != 32'd0)
                            r_len <= 4'(dlmr_pkg::DIGITS);
                        else if (r_len == 4'd0)
                            r_len <= 4'd1;
                        r_idx <= '0;
                        r_acc <= '0;
                    end else begin
                        if (r_va != 32'd0 || r_vb != 32'd0) r_len <= r_idx + 4'd1;
                        r_idx <= r_idx + 4'd1;
                    end
                end
                dlmr_pkg::ST_MIX: begin
                    // first position ends up most significant: walk from first to last
                    r_acc <= w_acc10;
                    if (r_idx == r_len - 4'd1) begin
                        r_val <= w_acc10;
                        if (r_op == dlmr_pkg::OP_RESEED) r_warm <= r_warm - 4'd1;
                    end else begin
                        r_idx <= r_idx + 4'd1;
                    end
                    r_span <= r_hi - r_lo + 64'd1;
                end
                dlmr_pkg::ST_RNG_PREP: if (r_span == 64'd0) r_ovalid <= 1'b1;
                dlmr_pkg::ST_RNG_ADD: begin
                    r_val    <= r_lo + w_rem;
                    r_ovalid <= 1'b1;
                end
                dlmr_pkg::ST_OUT: if (w_out_acc) r_ovalid <= 1'b0;
                default: begin
                end
            endcase
            if (r_state == dlmr_pkg::ST_MIX && r_idx == r_len - 4'd1
                && r_op == dlmr_pkg::OP_NEXT)
                r_ovalid <= 1'b1;
        end
    end
endmodule
